// File: hdl/fupd_pkg.sv
// Shared types and codes for the file URI path decoder.
// Used by the front, queue and back modules; depends on nothing.
package fupd_pkg;

    // Final status of one URI, reported with its last beat.
    typedef enum logic [2:0] {
        ST_PENDING    = 3'd0,
        ST_OK         = 3'd1,
        ST_BAD_SCHEME = 3'd2,
        ST_NO_SLASH   = 3'd3,
        ST_BAD_HOST   = 3'd4,
        ST_TRUNCATED  = 3'd5,
        ST_BAD_HEX    = 3'd6
    } t_status;

    // One input byte together with everything the back end needs to know about it.
    // pfx_hit[k] is set when the byte equals prefix character k; bit 7 is always 0.
    // loc_hit[k] is set when the byte equals host character k; bits 9 to 15 are 0.
    typedef struct packed {
        logic [7:0]  uri_byte;
        logic        last_byte;
        logic        is_slash;
        logic        is_pct;
        logic        hex_ok;
        logic [3:0]  hex_val;
        logic [7:0]  pfx_hit;
        logic [15:0] loc_hit;
    } t_class;

    // One result beat.
    typedef struct packed {
        logic [7:0] path_byte;
        logic       byte_valid;
        logic       final_res;
        t_status    status;
    } t_result;

endpackage

// File: hdl/fupd_if.sv
// Stream interfaces for the decoder's input and output channels.
// Each carries valid, ready and the payload; no dependencies.
interface fupd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] uri_byte;
    logic       last_byte;

    modport source (output valid, output uri_byte, output last_byte, input ready);
    modport sink (input valid, input uri_byte, input last_byte, output ready);
endinterface

interface fupd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       byte_valid;
    logic       final_res;
    logic [2:0] status;

    modport source (output valid, output path_byte, output byte_valid,
                    output final_res, output status, input ready);
    modport sink (input valid, input path_byte, input byte_valid,
                  input final_res, input status, output ready);
endinterface

// File: hdl/fupd_front.sv
// Front end: accepts URI beats and classifies each byte into a t_class record.
// Depends on fupd_pkg and fupd_in_if; feeds fupd_queue.
module fupd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fupd_in_if.sink         i_in,
    output logic            o_push,
    output fupd_pkg::t_class o_class,
    input  logic            i_queue_ready
);
    import fupd_pkg::*;

    localparam logic [7:0] PREFIX_TEXT [7] = '{8'h66, 8'h69, 8'h6C, 8'h65, 8'h3A, 8'h2F, 8'h2F};
    localparam logic [7:0] LOCAL_TEXT [9] =
        '{8'h6C, 8'h6F, 8'h63, 8'h61, 8'h6C, 8'h68, 8'h6F, 8'h73, 8'h74};
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;

    logic   r_valid;
    t_class r_class;
    t_class n_class;
    logic   take;

    always_comb begin
        n_class           = '0;
        n_class.uri_byte  = i_in.uri_byte;
        n_class.last_byte = i_in.last_byte;
        n_class.is_slash  = (i_in.uri_byte == CH_SLASH);
        n_class.is_pct    = (i_in.uri_byte == CH_PCT);
        if (i_in.uri_byte inside {[8'h30:8'h39]}) begin
            n_class.hex_ok  = 1'b1;
            n_class.hex_val = i_in.uri_byte[3:0];
        end else if (i_in.uri_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            n_class.hex_ok  = 1'b1;
            n_class.hex_val = i_in.uri_byte[3:0] + 4'd9;
        end
        for (int k = 0; k < 7; k++) begin
            n_class.pfx_hit[k] = (i_in.uri_byte == PREFIX_TEXT[k]);
        end
        for (int k = 0; k < 9; k++) begin
            n_class.loc_hit[k] = (i_in.uri_byte == LOCAL_TEXT[k]);
        end
    end

    // The stage refills in the same cycle that it drains into the queue.
    assign i_in.ready = !r_valid || i_queue_ready;
    assign take       = i_in.valid && i_in.ready;
    assign o_push     = r_valid;
    assign o_class    = r_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_queue_ready) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_class <= n_class;
        end
    end

endmodule

// File: hdl/fupd_queue.sv
// Short FIFO of classified beats between the front and the back end.
// Depends on fupd_pkg; depth is set by the DEPTH parameter.
module fupd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fupd_pkg::t_class i_class,
    output logic             o_ready,
    output logic             o_valid,
    output fupd_pkg::t_class o_class,
    input  logic             i_pop
);
    import fupd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_class          r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_class = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_class;
        end
    end

endmodule

// File: hdl/fupd_back.sv
// Back end: the URI parsing state machine and the registered output beat.
// Depends on fupd_pkg and fupd_out_if; pops classified beats from fupd_queue.
module fupd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fupd_pkg::t_class i_class,
    output logic             o_pop,
    fupd_out_if.source       o_out
);
    import fupd_pkg::*;

    typedef enum logic [2:0] {
        PH_SCHEME,
        PH_HOST,
        PH_PATH,
        PH_ESC_HI,
        PH_ESC_LO,
        PH_FAILED
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [2:0] r_pos, n_pos;
    logic [3:0] r_host_len, n_host_len;
    logic       r_host_mism, n_host_mism;
    logic [3:0] r_high, n_high;
    logic       r_hex_bad, n_hex_bad;
    t_status    r_err, n_err;
    logic       r_out_valid;
    t_result    r_out, n_out;

    assign o_pop = i_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_host_len  = r_host_len;
        n_host_mism = r_host_mism;
        n_high      = r_high;
        n_hex_bad   = r_hex_bad;
        n_err       = r_err;
        n_out       = '0;
        n_out.status = ST_PENDING;

        case (r_phase)
            PH_SCHEME: begin
                if (i_class.pfx_hit[r_pos]) begin
                    n_pos = r_pos + 3'd1;
                    if (r_pos == 3'd6) begin
                        n_phase = PH_HOST;
                    end
                end else begin
                    n_err   = ST_BAD_SCHEME;
                    n_phase = PH_FAILED;
                end
            end
            PH_HOST: begin
                if (i_class.is_slash) begin
                    if (r_host_len == 4'd0 || (r_host_len == 4'd9 && !r_host_mism)) begin
                        n_out.path_byte  = i_class.uri_byte;
                        n_out.byte_valid = 1'b1;
                        n_phase          = PH_PATH;
                    end else begin
                        n_err   = ST_BAD_HOST;
                        n_phase = PH_FAILED;
                    end
                end else begin
                    // loc_hit is zero past the ninth character, so long hosts mismatch.
                    if (!i_class.loc_hit[r_host_len]) begin
                        n_host_mism = 1'b1;
                    end
                    if (r_host_len != 4'd15) begin
                        n_host_len = r_host_len + 4'd1;
                    end
                end
            end
            PH_PATH: begin
                if (i_class.is_pct) begin
                    n_phase = PH_ESC_HI;
                end else begin
                    n_out.path_byte  = i_class.uri_byte;
                    n_out.byte_valid = 1'b1;
                end
            end
            PH_ESC_HI: begin
                n_hex_bad = !i_class.hex_ok;
                n_high    = i_class.hex_val;
                n_phase   = PH_ESC_LO;
            end
            PH_ESC_LO: begin
                if (r_hex_bad || !i_class.hex_ok) begin
                    n_err   = ST_BAD_HEX;
                    n_phase = PH_FAILED;
                end else begin
                    n_out.path_byte  = {r_high, i_class.hex_val};
                    n_out.byte_valid = 1'b1;
                    n_phase          = PH_PATH;
                end
            end
            default: begin
                n_phase = PH_FAILED;
            end
        endcase

        // The last beat reports the outcome and returns everything to the reset state.
        if (i_class.last_byte) begin
            n_out.final_res = 1'b1;
            if (n_err != ST_PENDING) begin
                n_out.status = n_err;
            end else if (n_phase == PH_SCHEME) begin
                n_out.status = ST_BAD_SCHEME;
            end else if (n_phase == PH_HOST) begin
                n_out.status = ST_NO_SLASH;
            end else if (n_phase == PH_ESC_HI || n_phase == PH_ESC_LO) begin
                n_out.status = ST_TRUNCATED;
            end else begin
                n_out.status = ST_OK;
            end
            n_phase     = PH_SCHEME;
            n_pos       = '0;
            n_host_len  = '0;
            n_host_mism = 1'b0;
            n_high      = '0;
            n_hex_bad   = 1'b0;
            n_err       = ST_PENDING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SCHEME;
            r_pos       <= '0;
            r_host_len  <= '0;
            r_host_mism <= 1'b0;
            r_high      <= '0;
            r_hex_bad   <= 1'b0;
            r_err       <= ST_PENDING;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_host_len  <= n_host_len;
                r_host_mism <= n_host_mism;
                r_high      <= n_high;
                r_hex_bad   <= n_hex_bad;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.path_byte  = r_out.path_byte;
    assign o_out.byte_valid = r_out.byte_valid;
    assign o_out.final_res  = r_out.final_res;
    assign o_out.status     = r_out.status;

    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_class.last_byte |=> r_phase == PH_SCHEME && r_err == ST_PENDING)
        else $error("state not cleared after the last beat of a URI");

    a_failed_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FAILED) == (r_err != ST_PENDING))
        else $error("failed phase and latched error code disagree");

    a_status_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.final_res == (r_out.status != ST_PENDING)))
        else $error("status reported on a beat that is not the last");

    a_no_byte_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && r_phase == PH_FAILED |=> !r_out.byte_valid)
        else $error("decoded byte emitted after an error was latched");

endmodule

// File: hdl/file_uri_path_decoder_core.sv
// Top level of the file URI path decoder: front, queue and back end.
// Depends on fupd_pkg, fupd_if, fupd_front, fupd_queue and fupd_back.
//
// Usage: the URI text arrives on i_in one byte per beat, with last_byte set on
// its final byte. For every input beat exactly one result beat leaves on o_out,
// in order. A result carries a decoded path byte when byte_valid is set, and the
// last result of a URI has final_res set and the final status (1 ok, 2 to 6 an
// error). The receiver drops the partial path when that status is an error.
// Path: a beat accepted on i_in passes through the classify register, a queue
// entry and the output register before its result shows on o_out.
// Throughput: one beat per cycle while o_out.ready stays high, set by the
// parsing state machine in the back end.
// Stall: while o_out.ready is low the output beat holds; the queue of
// QUEUE_DEPTH entries and the front register keep taking input until full,
// then i_in.ready falls. Reset (synchronous, active low) empties the queue and
// the output register and returns the parser to the start of a URI.
// After each last byte the parser returns to that state by itself.
module file_uri_path_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fupd_in_if.sink     i_in,
    fupd_out_if.source  o_out
);
    import fupd_pkg::*;

    logic   front_push;
    t_class front_class;
    logic   queue_ready;
    logic   queue_valid;
    t_class queue_class;
    logic   back_pop;

    fupd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_push        (front_push),
        .o_class       (front_class),
        .i_queue_ready (queue_ready)
    );

    fupd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_class (front_class),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_class (queue_class),
        .i_pop   (back_pop)
    );

    fupd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_class (queue_class),
        .o_pop   (back_pop),
        .o_out   (o_out)
    );

endmodule
